// ----- sv/pd_pkg.sv -----
// Package for the percent decoder: the job type that passes from front to back,
// the queue depth and the hex digit helpers.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pd_pkg;

  localparam logic [7:0] PercentChar = 8'h25;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned MaxJobBytes = 3;

  // One accepted item turns into a job of zero to three output bytes.
  typedef struct packed {
    logic [1:0]                  num;
    logic [MaxJobBytes-1:0][7:0] bytes;
    logic                        last;
  } pd_job_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/pd_front.sv -----
// Front part of the percent decoder: accepts items, keeps the two-byte window
// and builds a job of output bytes for each item. Uses pd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pd_front import pd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output pd_job_t         job_o
);

  logic [7:0] win0_q, win0_d;
  logic [7:0] win1_q, win1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       accept;
  logic       escape;
  logic       emit;
  logic [7:0] emit_byte;
  logic [7:0] nw0, nw1;
  logic [1:0] ncnt;
  logic [1:0] flush;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign escape = (win0_q == PercentChar) && is_hex(win1_q) && is_hex(in_byte_i);

  always_comb begin
    nw0       = win0_q;
    nw1       = win1_q;
    ncnt      = cnt_q;
    emit      = 1'b0;
    emit_byte = win0_q;
    if (cnt_q == 2'd0) begin
      nw0  = in_byte_i;
      ncnt = 2'd1;
    end else if (cnt_q == 2'd1) begin
      nw1  = in_byte_i;
      ncnt = 2'd2;
    end else if (escape) begin
      emit      = 1'b1;
      emit_byte = {hex_val(win1_q), hex_val(in_byte_i)};
      nw0       = 8'h00;
      nw1       = 8'h00;
      ncnt      = 2'd0;
    end else begin
      emit = 1'b1;
      nw0  = win1_q;
      nw1  = in_byte_i;
      ncnt = 2'd2;
    end
  end

  // The flushed window bytes follow the emitted byte, if there is one.
  always_comb begin
    flush     = in_last_i ? ncnt : 2'd0;
    job_o.num = flush + {1'b0, emit};
    job_o.last = in_last_i;
    if (emit) begin
      job_o.bytes = {nw1, nw0, emit_byte};
    end else begin
      job_o.bytes = {8'h00, nw1, nw0};
    end
  end

  assign push_o = accept && (job_o.num != 2'd0);

  always_comb begin
    win0_d = win0_q;
    win1_d = win1_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (in_last_i) begin
        win0_d = 8'h00;
        win1_d = 8'h00;
        cnt_d  = 2'd0;
      end else begin
        win0_d = nw0;
        win1_d = nw1;
        cnt_d  = ncnt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win0_q <= 8'h00;
      win1_q <= 8'h00;
      cnt_q  <= 2'd0;
    end else begin
      win0_q <= win0_d;
      win1_q <= win1_d;
      cnt_q  <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("window count out of range");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_last_i) |=> (cnt_q == 2'd0))
    else $error("window not emptied after the final item");

  a_last_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_last_i) |-> push_o)
    else $error("final item produced no output");
`endif

endmodule

`default_nettype wire

// ----- sv/pd_queue.sv -----
// Short job queue between the front and back parts of the percent decoder.
// Register-based FIFO of pd_job_t entries. Uses pd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pd_queue import pd_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire pd_job_t job_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         valid_o,
  output pd_job_t      job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pd_job_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

// ----- sv/pd_back.sv -----
// Back of the percent decoder, uses pd_pkg: takes queued jobs and sends their
// bytes out one item per cycle, when not stalled, via an output register.
`timescale 1ns / 1ps
`default_nettype none

module pd_back import pd_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    q_valid_i,
  input  wire pd_job_t job_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output logic [7:0]   out_byte_o,
  output logic         out_last_o
);

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic [1:0] idx_q, idx_d;
  logic       load;
  logic       final_byte;

  // The output register may be refilled when empty or when its item leaves.
  assign load       = q_valid_i && (!out_valid_q || !out_stall_i);
  assign final_byte = (idx_q == (job_i.num - 2'd1));
  assign pop_o      = load && final_byte;

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    idx_d       = idx_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_byte_d  = job_i.bytes[idx_q];
      out_last_d  = job_i.last && final_byte;
      idx_d       = final_byte ? 2'd0 : idx_q + 2'd1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

`ifndef NO_ASSERTIONS
  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_i |-> (idx_q < job_i.num))
    else $error("byte index beyond the current job");

  a_idx_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (idx_q == 2'd0))
    else $error("byte index not reset after a job completes");
`endif

endmodule

`default_nettype wire

// ----- sv/percent_decoder_core.sv -----
// Streaming URL percent decoder, top level.
// Input channel: one raw byte per item with a final-byte flag (in_valid_i,
// in_stall_o). Output channel: one decoded byte per item with a final flag
// (out_valid_o, out_stall_i). An item moves when valid is high and stall low.
// The front keeps a two-byte window; a '%' followed by two hex digits of
// either case becomes one byte, anything else passes through in order.
// The final input item flushes the window, and its last output item carries
// out_last_o. Each input item yields zero to three output items.
// An accepted input item's job is written into the job queue, and its bytes
// then move from the queue head into the output register. Throughput: one
// input item per cycle while out_stall_i is low, set by the single output
// register; only a final item that yields two or three output items holds
// the output longer, and if such items come close together the job queue
// (QDepth entries) fills and raises in_stall_o.
// Reset empties the window, the queue and the output register. A stalled
// receiver holds the output item steady; the queue absorbs the front until
// full.
`timescale 1ns / 1ps
`default_nettype none

module percent_decoder_core import pd_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);

  logic    q_full;
  logic    q_push;
  logic    q_pop;
  logic    q_valid;
  pd_job_t push_job;
  pd_job_t head_job;

  pd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .job_o      (push_job)
  );

  pd_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  pd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .job_i       (head_job),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

`default_nettype wire
